### rtl/afd_pkg.sv
`timescale 1ns / 1ps
// afd_pkg: shared types and constants for the angle frame decoder
// beat structs, frame layout constants and the angle scaling function
// no dependencies

package afd_pkg;

    localparam logic [7:0] FRAME_HEADER   = 8'h55;
    localparam logic [7:0] TYPE_RESET     = 8'h53;
    localparam int         FRAME_LEN      = 11;
    localparam int         ANGLE_BYTES    = 6;
    localparam int         ANGLE_AXES     = 3;
    localparam int         RAW_W          = 16;
    localparam int         DEG_W          = 24;
    localparam int         POS_W          = 4;
    localparam int         ANGLE_IDX_W    = 3;
    localparam logic [POS_W-1:0] POS_IDLE     = 4'd0;
    localparam logic [POS_W-1:0] POS_TYPE     = 4'd1;
    localparam logic [POS_W-1:0] POS_ANGLE_LO = 4'd2;
    localparam logic [POS_W-1:0] POS_ANGLE_HI = 4'd7;
    localparam logic [POS_W-1:0] POS_CHECKSUM = 4'd10;
    localparam logic [8:0]       DEG_SCALE    = 9'd180;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_beat_t;

    typedef struct packed {
        logic                    frame_ok;
        logic signed [DEG_W-1:0] roll_deg;
        logic signed [DEG_W-1:0] pitch_deg;
        logic signed [DEG_W-1:0] yaw_deg;
    } out_beat_t;

    // raw held angles handed from the frame tracker to the scaling stage
    typedef struct packed {
        logic             ok;
        logic [RAW_W-1:0] roll_raw;
        logic [RAW_W-1:0] pitch_raw;
        logic [RAW_W-1:0] yaw_raw;
    } frame_event_t;

    // raw int16 times 180, exact in 24 bits
    function automatic logic signed [DEG_W-1:0] scale_angle(input logic [RAW_W-1:0] raw);
        logic [DEG_W:0] ext;
        logic [DEG_W:0] prod;
        ext  = {{(DEG_W + 1 - RAW_W){raw[RAW_W-1]}}, raw};
        prod = ext * {{(DEG_W + 1 - 9){1'b0}}, DEG_SCALE};
        return $signed(prod[DEG_W-1:0]);
    endfunction

endpackage

### rtl/afd_frame_tracker.sv
`timescale 1ns / 1ps
// afd_frame_tracker: byte position, running sum, prefix check and angle capture
// raises one registered frame event per completed frame
// depends on afd_pkg

module afd_frame_tracker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  afd_pkg::in_beat_t     in_data,
    output logic                  evt_valid,
    input  logic                  evt_ready,
    output afd_pkg::frame_event_t evt_data
);

    logic [7:0]                 type_reg;
    logic [afd_pkg::POS_W-1:0]  pos_reg;
    logic [afd_pkg::POS_W-1:0]  pos_next;
    logic [7:0]                 sum_reg;
    logic [7:0]                 sum_next;
    logic                       prefix_reg;
    logic                       prefix_next;
    logic [7:0]                 angle_byte_reg [afd_pkg::ANGLE_BYTES];
    logic [afd_pkg::RAW_W-1:0]  held_reg [afd_pkg::ANGLE_AXES];
    logic [afd_pkg::RAW_W-1:0]  new_raw [afd_pkg::ANGLE_AXES];
    logic                       evt_valid_reg;
    afd_pkg::frame_event_t      evt_data_reg;
    afd_pkg::frame_event_t      evt_data_next;
    logic                       accept;
    logic                       angle_we;
    logic [afd_pkg::ANGLE_IDX_W-1:0] angle_idx;
    logic                       fire;
    logic                       ok;
    logic [afd_pkg::POS_W-1:0]  angle_off;

    assign in_ready  = !evt_valid_reg || evt_ready;
    assign accept    = in_valid && in_ready;
    assign evt_valid = evt_valid_reg;
    assign evt_data  = evt_data_reg;
    assign angle_off = pos_reg - afd_pkg::POS_ANGLE_LO;
    assign angle_idx = angle_off[afd_pkg::ANGLE_IDX_W-1:0];

    always_comb
    begin
        for (int k = 0; k < afd_pkg::ANGLE_AXES; k++)
        begin
            new_raw[k] = {angle_byte_reg[2*k+1], angle_byte_reg[2*k]};
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        prefix_next = prefix_reg;
        angle_we    = 1'b0;
        fire        = 1'b0;
        ok          = prefix_reg && (sum_reg == in_data.rx_byte);
        if (in_data.frame_start)
        begin
            prefix_next = (in_data.rx_byte == afd_pkg::FRAME_HEADER);
            sum_next    = in_data.rx_byte;
            pos_next    = afd_pkg::POS_TYPE;
        end
        else if (pos_reg == afd_pkg::POS_IDLE || pos_reg > afd_pkg::POS_CHECKSUM)
        begin
            pos_next = afd_pkg::POS_IDLE;
        end
        else if (pos_reg < afd_pkg::POS_CHECKSUM)
        begin
            if (pos_reg == afd_pkg::POS_TYPE)
            begin
                prefix_next = prefix_reg && (in_data.rx_byte == type_reg);
            end
            else if (pos_reg <= afd_pkg::POS_ANGLE_HI)
            begin
                angle_we = 1'b1;
            end
            sum_next = sum_reg + in_data.rx_byte;
            pos_next = pos_reg + 1'b1;
        end
        else
        begin
            fire        = 1'b1;
            pos_next    = afd_pkg::POS_IDLE;
            sum_next    = 8'd0;
            prefix_next = 1'b0;
        end

        evt_data_next.ok        = ok;
        evt_data_next.roll_raw  = ok ? new_raw[0] : held_reg[0];
        evt_data_next.pitch_raw = ok ? new_raw[1] : held_reg[1];
        evt_data_next.yaw_raw   = ok ? new_raw[2] : held_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg      <= afd_pkg::TYPE_RESET;
            pos_reg       <= afd_pkg::POS_IDLE;
            sum_reg       <= 8'd0;
            prefix_reg    <= 1'b0;
            evt_valid_reg <= 1'b0;
            for (int k = 0; k < afd_pkg::ANGLE_AXES; k++)
            begin
                held_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                type_reg <= cfg_data;
            end
            if (accept)
            begin
                pos_reg    <= pos_next;
                sum_reg    <= sum_next;
                prefix_reg <= prefix_next;
                if (fire && ok)
                begin
                    for (int k = 0; k < afd_pkg::ANGLE_AXES; k++)
                    begin
                        held_reg[k] <= new_raw[k];
                    end
                end
            end
            if (accept && fire)
            begin
                evt_valid_reg <= 1'b1;
            end
            else if (evt_ready)
            begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (accept && angle_we)
        begin
            angle_byte_reg[angle_idx] <= in_data.rx_byte;
        end
        if (accept && fire)
        begin
            evt_data_reg <= evt_data_next;
        end
    end

endmodule

### rtl/afd_angle_scale.sv
`timescale 1ns / 1ps
// afd_angle_scale: turns raw held angles into degrees and holds the result beat
// one multiply by 180 per axis between the event register and the output register
// depends on afd_pkg

module afd_angle_scale
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  evt_valid,
    output logic                  evt_ready,
    input  afd_pkg::frame_event_t evt_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output afd_pkg::out_beat_t    out_data
);

    logic               out_valid_reg;
    afd_pkg::out_beat_t out_data_reg;
    afd_pkg::out_beat_t out_data_next;

    assign evt_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_data_next.frame_ok  = evt_data.ok;
        out_data_next.roll_deg  = afd_pkg::scale_angle(evt_data.roll_raw);
        out_data_next.pitch_deg = afd_pkg::scale_angle(evt_data.pitch_raw);
        out_data_next.yaw_deg   = afd_pkg::scale_angle(evt_data.yaw_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (evt_ready)
        begin
            out_valid_reg <= evt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_ready && evt_valid)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

### rtl/angle_frame_decoder_unit.sv
`timescale 1ns / 1ps
// angle_frame_decoder_unit: top level of the 11-byte angle frame decoder
// instantiates afd_frame_tracker and afd_angle_scale, uses afd_pkg
//
//  channel  | signals                      | beat
//  ---------+------------------------------+-------------------------------------
//  in       | in_valid / in_ready          | in_data: rx_byte, frame_start
//  out      | out_valid / out_ready        | out_data: frame_ok, roll/pitch/yaw_deg
//  cfg      | cfg_we (no wait)             | cfg_data: expected frame type byte
//
// one input beat per cycle while in_ready is high; a checksum beat's result is registered
// in the event register in the tracker, then in the output register behind the x180 multipliers
// every other beat only updates the frame state and gives no result
// reset: position, sum, prefix flag and held angles clear, type byte returns to 0x53
// a stalled output holds its beat; one more result waits in the event register,
// after which in_ready drops until the output side moves

module angle_frame_decoder_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  afd_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output afd_pkg::out_beat_t out_data
);

    // frame event between tracker and scaling stage
    logic                  evt_valid;
    logic                  evt_ready;
    afd_pkg::frame_event_t evt_data;

    // byte position, running sum, header/type check, angle bytes and held angles
    afd_frame_tracker u_tracker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_data  (evt_data)
    );

    // raw int16 times 180 into the output register
    afd_angle_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_data  (evt_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### rtl/afd_checker.sv
`timescale 1ns / 1ps
// afd_checker: port-level assertions for angle_frame_decoder_unit, with its bind
// watches the handshakes, the backpressure relation and the held-angle behaviour
// depends on afd_pkg

module afd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input afd_pkg::in_beat_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input afd_pkg::out_beat_t out_data
);

    logic                          out_fire;
    logic signed [afd_pkg::DEG_W-1:0] last_roll_reg;
    logic signed [afd_pkg::DEG_W-1:0] last_pitch_reg;
    logic signed [afd_pkg::DEG_W-1:0] last_yaw_reg;

    assign out_fire = out_valid && out_ready;

    // angles of the last delivered beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_roll_reg  <= '0;
            last_pitch_reg <= '0;
            last_yaw_reg   <= '0;
        end
        else if (out_fire)
        begin
            last_roll_reg  <= out_data.roll_deg;
            last_pitch_reg <= out_data.pitch_deg;
            last_yaw_reg   <= out_data.yaw_deg;
        end
    end

    // a waiting input beat holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat changed while waiting");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // input stalls only when both result slots are full and the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // a rejected frame reports the angles delivered before it
    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.frame_ok |->
            out_data.roll_deg == last_roll_reg && out_data.pitch_deg == last_pitch_reg &&
            out_data.yaw_deg == last_yaw_reg)
        else $error("rejected frame changed the held angles");

    // scaled angles stay in the int16 times 180 range
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            out_data.roll_deg  >= -24'sd5898240 && out_data.roll_deg  <= 24'sd5898060 &&
            out_data.pitch_deg >= -24'sd5898240 && out_data.pitch_deg <= 24'sd5898060 &&
            out_data.yaw_deg   >= -24'sd5898240 && out_data.yaw_deg   <= 24'sd5898060)
        else $error("scaled angle out of range");

endmodule

bind angle_frame_decoder_unit afd_checker u_afd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for angle_frame_decoder_unit
// drives frame bytes with random gaps and output stalls and checks each result
// beat against a local frame tracker; depends on afd_pkg and the rtl top level

module tb_top;

    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 155;
    // time for the pipeline registers to empty, plus margin
    localparam int SETTLE_CYCLES = 6;

    // the directed table: one byte per row, an expected result typed in where obvious
    typedef struct packed {
        logic [7:0]         rx;
        logic               start;
        logic               typed;
        afd_pkg::out_beat_t want;
    } stim_row_t;

    // full-scale angles: roll 0x8000, pitch 0x7fff, yaw 0xffff
    localparam afd_pkg::out_beat_t WANT_EXTREMES =
        {1'b1, -24'sd5898240, 24'sd5898060, -24'sd180};
    // bad checksum: same angles held, frame rejected
    localparam afd_pkg::out_beat_t WANT_HELD =
        {1'b0, -24'sd5898240, 24'sd5898060, -24'sd180};

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [7:0]         cfg_data  = 8'h00;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    afd_pkg::in_beat_t  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    afd_pkg::out_beat_t out_data;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int beats_tracked  = 0;

    // results owed by the block, oldest first
    afd_pkg::out_beat_t angle_reports_due [$];
    stim_row_t directed_rows [$];

    // scratch frame shared by the frame builders
    logic [7:0] frame_buf [11];

    // local copy of the decoder state, reset values given here
    logic [7:0]                trk_type      = afd_pkg::TYPE_RESET;
    logic [afd_pkg::POS_W-1:0] trk_pos       = afd_pkg::POS_IDLE;
    logic [7:0]                trk_sum       = 8'h00;
    logic                      trk_prefix_ok = 1'b0;
    logic [7:0]                trk_angle_bytes [afd_pkg::ANGLE_BYTES];
    logic [afd_pkg::RAW_W-1:0] trk_held_raw [afd_pkg::ANGLE_AXES] = '{default: '0};

    angle_frame_decoder_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hard stop should the block hang
    initial
    begin
        #8_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // signed raw angle times 180, kept to the 24-bit output width
    function automatic logic signed [afd_pkg::DEG_W-1:0] raw_to_deg(
        input logic [afd_pkg::RAW_W-1:0] raw);
        int wide;
        wide = int'($signed(raw)) * 180;
        return wide[afd_pkg::DEG_W-1:0];
    endfunction

    // advance the local tracker by one accepted byte; returns 0 for a byte the block ignores
    function automatic bit track_frame_byte(input afd_pkg::in_beat_t b, output bit gives_report,
                                            output afd_pkg::out_beat_t report);
        bit ok;
        gives_report = 1'b0;
        report       = '0;
        // a start marker always opens a new frame, even mid-frame
        if (b.frame_start)
        begin
            trk_prefix_ok = (b.rx_byte == afd_pkg::FRAME_HEADER);
            trk_sum       = b.rx_byte;
            trk_pos       = afd_pkg::POS_TYPE;
            return 1'b1;
        end
        // stray byte with no frame open
        if (trk_pos == afd_pkg::POS_IDLE || int'(trk_pos) >= afd_pkg::FRAME_LEN)
        begin
            trk_pos = afd_pkg::POS_IDLE;
            return 1'b0;
        end
        if (trk_pos < afd_pkg::POS_CHECKSUM)
        begin
            // type byte is judged against the register as it stands now
            if (trk_pos == afd_pkg::POS_TYPE)
                trk_prefix_ok = trk_prefix_ok && (b.rx_byte == trk_type);
            else if (trk_pos <= afd_pkg::POS_ANGLE_HI)
                trk_angle_bytes[trk_pos - afd_pkg::POS_ANGLE_LO] = b.rx_byte;
            trk_sum = trk_sum + b.rx_byte;
            trk_pos = trk_pos + 1'b1;
            return 1'b1;
        end
        // checksum byte closes the frame
        ok = trk_prefix_ok && (trk_sum == b.rx_byte);
        if (ok)
            for (int k = 0; k < afd_pkg::ANGLE_AXES; k++)
                trk_held_raw[k] = {trk_angle_bytes[2*k+1], trk_angle_bytes[2*k]};
        trk_pos       = afd_pkg::POS_IDLE;
        trk_sum       = 8'h00;
        trk_prefix_ok = 1'b0;
        gives_report       = 1'b1;
        report.frame_ok    = ok;
        report.roll_deg    = raw_to_deg(trk_held_raw[0]);
        report.pitch_deg   = raw_to_deg(trk_held_raw[1]);
        report.yaw_deg     = raw_to_deg(trk_held_raw[2]);
        return 1'b1;
    endfunction

    function automatic stim_row_t stim_row(input logic [7:0] rx, input logic start,
                                           input logic typed, input afd_pkg::out_beat_t want);
        stim_row_t r;
        r.rx    = rx;
        r.start = start;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // well-formed frame with the given type byte and a correct checksum;
    // angle and spare bytes lean towards the sign and full-scale edges
    function automatic void fill_frame(input logic [7:0] type_byte);
        logic [7:0] sum;
        frame_buf[0] = afd_pkg::FRAME_HEADER;
        frame_buf[1] = type_byte;
        for (int i = 2; i < 10; i++)
            case ($urandom_range(11))
                0:       frame_buf[i] = 8'h00;
                1:       frame_buf[i] = 8'hFF;
                2:       frame_buf[i] = 8'h80;
                3:       frame_buf[i] = 8'h7F;
                default: frame_buf[i] = 8'($urandom);
            endcase
        sum = 8'h00;
        for (int i = 0; i < 10; i++)
            sum = sum + frame_buf[i];
        frame_buf[10] = sum;
    endfunction

    // present one input beat, hold it until accepted, then book the expected result;
    // called at a rising edge and returns at the edge that took the beat
    task automatic send_beat(input afd_pkg::in_beat_t b, input bit typed,
                             input afd_pkg::out_beat_t want);
        bit                 made;
        bit                 counted;
        afd_pkg::out_beat_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        counted = track_frame_byte(b, made, predicted);
        if (counted)
            beats_tracked++;
        if (made)
            angle_reports_due.push_back(typed ? want : predicted);
    endtask

    task automatic send_frame_bytes(input int first, input int last);
        for (int i = first; i <= last; i++)
            send_beat({frame_buf[i], i == 0}, 1'b0, '0);
    endtask

    // let every owed result arrive, then give the pipeline time to empty
    task automatic drain_results();
        in_valid <= 1'b0;
        while (angle_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_expected_type(input logic [7:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        trk_type  = value;
    endtask

    // mostly whole frames with occasional damage, the rest cut-off frames and noise
    task automatic send_random_event();
        int pick;
        int noise_len;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            fill_frame(($urandom_range(9) == 0) ? 8'($urandom) : trk_type);
            if ($urandom_range(19) == 0)
                frame_buf[0] = 8'($urandom);
            if ($urandom_range(9) == 0)
                frame_buf[10] = frame_buf[10] ^ 8'($urandom_range(1, 255));
            send_frame_bytes(0, 10);
        end
        else if (pick < 82)
        begin
            // stops short; the next start marker abandons it
            fill_frame(trk_type);
            send_frame_bytes(0, $urandom_range(0, 9));
        end
        else if (pick < 92)
        begin
            noise_len = $urandom_range(1, 4);
            repeat (noise_len) send_beat({8'($urandom), 1'b0}, 1'b0, '0);
        end
        else
            send_beat({8'($urandom), 1'($urandom)}, 1'b0, '0);
    endtask

    // result side: check each taken beat against the oldest owed result, then
    // choose the next cycle's ready
    always @(posedge clk)
    begin : report_check
        afd_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (angle_reports_due.size() == 0)
            begin
                $display("%0t: result beat with none owed, got ok=%0d roll=%0d pitch=%0d yaw=%0d",
                         $time, out_data.frame_ok, out_data.roll_deg, out_data.pitch_deg,
                         out_data.yaw_deg);
                mismatch_count++;
            end
            else
            begin
                want = angle_reports_due.pop_front();
                if (out_data.frame_ok !== want.frame_ok)
                begin
                    $display("%0t: frame_ok expected %0d got %0d",
                             $time, want.frame_ok, out_data.frame_ok);
                    mismatch_count++;
                end
                if (out_data.roll_deg !== want.roll_deg)
                begin
                    $display("%0t: roll_deg expected %0d got %0d",
                             $time, want.roll_deg, out_data.roll_deg);
                    mismatch_count++;
                end
                if (out_data.pitch_deg !== want.pitch_deg)
                begin
                    $display("%0t: pitch_deg expected %0d got %0d",
                             $time, want.pitch_deg, out_data.pitch_deg);
                    mismatch_count++;
                end
                if (out_data.yaw_deg !== want.yaw_deg)
                begin
                    $display("%0t: yaw_deg expected %0d got %0d",
                             $time, want.yaw_deg, out_data.yaw_deg);
                    mismatch_count++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial
    begin : stimulus
        stim_row_t  r;
        logic [7:0] next_type;
        logic [7:0] open_type;
        int         split;
        int         goal;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray byte with no frame open is dropped
        directed_rows.push_back(stim_row(8'h55, 1'b0, 1'b0, '0));
        // a frame cut short after its type byte
        directed_rows.push_back(stim_row(8'h55, 1'b1, 1'b0, '0));
        directed_rows.push_back(stim_row(8'h53, 1'b0, 1'b0, '0));
        // start marker mid-frame, then a good frame at full scale
        directed_rows.push_back(stim_row(8'h55, 1'b1, 1'b0, '0));
        directed_rows.push_back(stim_row(8'h53, 1'b0, 1'b0, '0));
        directed_rows.push_back(stim_row(8'h00, 1'b0, 1'b0, '0));
        directed_rows.push_back(stim_row(8'h80, 1'b0, 1'b0, '0));
        directed_rows.push_back(stim_row(8'hFF, 1'b0, 1'b0, '0));
        directed_rows.push_back(stim_row(8'h7F, 1'b0, 1'b0, '0));
        directed_rows.push_back(stim_row(8'hFF, 1'b0, 1'b0, '0));
        directed_rows.push_back(stim_row(8'hFF, 1'b0, 1'b0, '0));
        directed_rows.push_back(stim_row(8'hFF, 1'b0, 1'b0, '0));
        directed_rows.push_back(stim_row(8'h00, 1'b0, 1'b0, '0));
        directed_rows.push_back(stim_row(8'hA3, 1'b0, 1'b1, WANT_EXTREMES));
        // checksum off: rejected, previous angles stay
        directed_rows.push_back(stim_row(8'h55, 1'b1, 1'b0, '0));
        directed_rows.push_back(stim_row(8'h53, 1'b0, 1'b0, '0));
        for (int v = 1; v <= 8; v++)
            directed_rows.push_back(stim_row(8'(v), 1'b0, 1'b0, '0));
        directed_rows.push_back(stim_row(8'h33, 1'b0, 1'b1, WANT_HELD));

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            send_beat({r.rx, r.start}, r.typed, r.want);
        end

        // random phases; each ends with a frame left open across a type change,
        // so the type byte lands either side of the register write
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 48; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 48; end
                default: begin src_idle_pct = 11; sink_stall_pct = 11; end
            endcase
            goal = beats_tracked + PHASE_BEATS;
            while (beats_tracked < goal)
                send_random_event();

            case (ph % 4)
                0:       next_type = 8'h00;
                1:       next_type = 8'hFF;
                2:       next_type = 8'($urandom);
                default: next_type = afd_pkg::TYPE_RESET;
            endcase
            open_type = $urandom_range(1) ? next_type : trk_type;
            fill_frame(open_type);
            split = $urandom_range(1, 2);
            send_frame_bytes(0, split - 1);
            drain_results();
            write_expected_type(next_type);
            send_frame_bytes(split, 10);
        end

        drain_results();
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
